[hdl/sfs_pkg.sv]
package sfs_pkg;

  localparam int MaxFrames  = 16;
  localparam int ParamDepth = 64;
  localparam int IdCount    = 256;

  localparam int IdW     = 8;
  localparam int ValW    = 32;
  localparam int ParamW  = 8;
  localparam int FrameW  = $clog2(MaxFrames);
  localparam int FcW     = $clog2(MaxFrames + 1);
  localparam int PdW     = $clog2(ParamDepth);
  localparam int PcW     = $clog2(ParamDepth + 1);
  localparam int MaskAw  = $clog2(IdCount);
  localparam int SweepW  = $clog2(IdCount + 1);
  localparam int VarAw   = MaskAw + FrameW;
  localparam int QDepth  = 2;

  typedef enum logic [2:0] {
    OP_PUSH_PARAM = 3'd0,
    OP_POP_PARAM  = 3'd1,
    OP_PUSH_FRAME = 3'd2,
    OP_POP_FRAME  = 3'd3,
    OP_CREATE     = 3'd4,
    OP_READ       = 3'd5,
    OP_WRITE      = 3'd6,
    OP_FREE       = 3'd7
  } sfs_op_e;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_NOT_FOUND   = 3'd1,
    ERR_PARAM_EMPTY = 3'd2,
    ERR_PARAM_FULL  = 3'd3,
    ERR_FRAME_EMPTY = 3'd4,
    ERR_FRAME_FULL  = 3'd5
  } sfs_err_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SWEEP
  } sfs_state_e;

  typedef struct packed {
    sfs_op_e                  op;
    logic                     id_ok;
    logic [IdW-1:0]           var_id;
    logic signed [ValW-1:0]   new_value;
    logic signed [ParamW-1:0] param_value;
    logic signed [ValW-1:0]   return_address;
  } sfs_item_t;

endpackage

[hdl/sfs_ram.sv]
module sfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sfs_front.sv]
module sfs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      action_i,
  input  logic [sfs_pkg::IdW-1:0]         var_id_i,
  input  logic signed [sfs_pkg::ValW-1:0] new_value_i,
  input  logic signed [sfs_pkg::ParamW-1:0] param_value_i,
  input  logic signed [sfs_pkg::ValW-1:0] return_address_i,
  output logic                            q_valid_o,
  output sfs_pkg::sfs_item_t              q_item_o,
  input  logic                            deq_i
);

  sfs_pkg::sfs_item_t slot_q [sfs_pkg::QDepth];
  sfs_pkg::sfs_item_t item;
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  logic               push;

  always_comb begin
    item.op             = sfs_pkg::sfs_op_e'(action_i);
    item.id_ok          = ({1'b0, var_id_i} < sfs_pkg::IdCount[sfs_pkg::IdW:0]);
    item.var_id         = var_id_i;
    item.new_value      = new_value_i;
    item.param_value    = param_value_i;
    item.return_address = return_address_i;
  end

  assign in_stall_o = (cnt_q == 2'(sfs_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (deq_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(deq_i);
    end
  end

endmodule

[hdl/sfs_back.sv]
module sfs_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  sfs_pkg::sfs_item_t                q_item_i,
  output logic                              deq_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sfs_pkg::ValW-1:0]   read_value_o,
  output logic signed [sfs_pkg::ParamW-1:0] popped_param_o,
  output logic signed [sfs_pkg::ValW-1:0]   popped_address_o,
  output logic [2:0]                        error_code_o
);

  localparam int MaxFrames = sfs_pkg::MaxFrames;

  sfs_pkg::sfs_state_e state_q, state_d;
  sfs_pkg::sfs_item_t  item_q;
  logic [sfs_pkg::PcW-1:0]    pc_q;
  logic [sfs_pkg::FcW-1:0]    fc_q;
  logic [sfs_pkg::ValW-1:0]   faddr_q [MaxFrames];
  logic [sfs_pkg::SweepW-1:0] cnt_q;
  logic [sfs_pkg::FrameW-1:0] col_q;

  logic                       out_valid_q;
  logic [sfs_pkg::ValW-1:0]   rd_q, pa_q;
  logic [sfs_pkg::ParamW-1:0] pp_q;
  sfs_pkg::sfs_err_e          err_q;

  // memory ports
  logic m_we, m_re, v_we, v_re, p_we, p_re;
  logic [sfs_pkg::MaskAw-1:0] m_waddr, m_raddr;
  logic [MaxFrames-1:0]       m_wdata, m_rdata;
  logic [sfs_pkg::VarAw-1:0]  v_waddr, v_raddr;
  logic [sfs_pkg::ValW-1:0]   v_wdata, v_rdata;
  logic [sfs_pkg::PdW-1:0]    p_waddr, p_raddr;
  logic [sfs_pkg::ParamW-1:0] p_wdata, p_rdata;

  logic                       out_free, done;
  logic                       pc_inc, pc_dec, fc_inc, fc_dec;
  logic [sfs_pkg::ValW-1:0]   rd_d, pa_d;
  logic [sfs_pkg::ParamW-1:0] pp_d;
  sfs_pkg::sfs_err_e          err_d;

  logic [MaxFrames-1:0]       hit;
  logic                       found;
  logic [sfs_pkg::FrameW-1:0] fidx, top;
  logic [sfs_pkg::FcW-1:0]    fc_m1;
  logic [sfs_pkg::PcW-1:0]    pc_m1;
  logic [sfs_pkg::SweepW-1:0] cnt_m1;

  assign out_free = !out_valid_q || !out_stall_i;
  assign fc_m1    = fc_q - 1'b1;
  assign pc_m1    = pc_q - 1'b1;
  assign cnt_m1   = cnt_q - 1'b1;
  assign top      = fc_m1[sfs_pkg::FrameW-1:0];

  // innermost live frame holding the id
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int k = 0; k < MaxFrames; k++) begin
      hit[k] = m_rdata[k] && (sfs_pkg::FcW'(k) < fc_q) && item_q.id_ok;
      if (hit[k]) begin
        found = 1'b1;
        fidx  = sfs_pkg::FrameW'(k);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sfs_pkg::ST_CLEAR: begin
        if (cnt_q == sfs_pkg::SweepW'(sfs_pkg::IdCount - 1)) state_d = sfs_pkg::ST_IDLE;
      end
      sfs_pkg::ST_IDLE: begin
        if (q_valid_i) state_d = sfs_pkg::ST_EXEC;
      end
      sfs_pkg::ST_EXEC: begin
        if (item_q.op == sfs_pkg::OP_READ && found) state_d = sfs_pkg::ST_RDATA;
        else if (fc_dec) state_d = sfs_pkg::ST_SWEEP;
        else if (done) state_d = sfs_pkg::ST_IDLE;
      end
      sfs_pkg::ST_RDATA: begin
        if (done) state_d = sfs_pkg::ST_IDLE;
      end
      sfs_pkg::ST_SWEEP: begin
        if (cnt_q == sfs_pkg::SweepW'(sfs_pkg::IdCount)) state_d = sfs_pkg::ST_IDLE;
      end
      default: state_d = sfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    deq_o   = 1'b0;
    m_we    = 1'b0;
    m_re    = 1'b0;
    m_waddr = '0;
    m_raddr = '0;
    m_wdata = '0;
    v_we    = 1'b0;
    v_re    = 1'b0;
    v_waddr = {item_q.var_id[sfs_pkg::MaskAw-1:0], fidx};
    v_raddr = {item_q.var_id[sfs_pkg::MaskAw-1:0], fidx};
    v_wdata = item_q.new_value;
    p_we    = 1'b0;
    p_re    = 1'b0;
    p_waddr = pc_q[sfs_pkg::PdW-1:0];
    p_raddr = pc_m1[sfs_pkg::PdW-1:0];
    p_wdata = item_q.param_value;
    done    = 1'b0;
    pc_inc  = 1'b0;
    pc_dec  = 1'b0;
    fc_inc  = 1'b0;
    fc_dec  = 1'b0;
    rd_d    = '0;
    pp_d    = '0;
    pa_d    = '0;
    err_d   = sfs_pkg::ERR_OK;
    case (state_q)
      sfs_pkg::ST_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = cnt_q[sfs_pkg::MaskAw-1:0];
      end
      sfs_pkg::ST_IDLE: begin
        deq_o   = q_valid_i;
        m_re    = q_valid_i;
        m_raddr = q_item_i.var_id[sfs_pkg::MaskAw-1:0];
        p_re    = q_valid_i;
      end
      sfs_pkg::ST_EXEC: begin
        done = out_free;
        case (item_q.op)
          sfs_pkg::OP_PUSH_PARAM: begin
            if (pc_q >= sfs_pkg::PcW'(sfs_pkg::ParamDepth)) begin
              err_d = sfs_pkg::ERR_PARAM_FULL;
            end else begin
              p_we   = out_free;
              pc_inc = out_free;
            end
          end
          sfs_pkg::OP_POP_PARAM: begin
            if (pc_q == '0) begin
              err_d = sfs_pkg::ERR_PARAM_EMPTY;
            end else begin
              pp_d   = p_rdata;
              pc_dec = out_free;
            end
          end
          sfs_pkg::OP_PUSH_FRAME: begin
            if (fc_q >= sfs_pkg::FcW'(MaxFrames)) err_d = sfs_pkg::ERR_FRAME_FULL;
            else fc_inc = out_free;
          end
          sfs_pkg::OP_POP_FRAME: begin
            if (fc_q == '0) begin
              err_d = sfs_pkg::ERR_FRAME_EMPTY;
            end else begin
              pa_d   = faddr_q[top];
              fc_dec = out_free;
            end
          end
          sfs_pkg::OP_CREATE: begin
            if (fc_q == '0) begin
              err_d = sfs_pkg::ERR_FRAME_EMPTY;
            end else if (!item_q.id_ok) begin
              err_d = sfs_pkg::ERR_NOT_FOUND;
            end else begin
              v_we    = out_free;
              v_waddr = {item_q.var_id[sfs_pkg::MaskAw-1:0], top};
              v_wdata = '0;
              m_we    = out_free;
              m_waddr = item_q.var_id[sfs_pkg::MaskAw-1:0];
              m_wdata = m_rdata | (MaxFrames'(1) << top);
            end
          end
          sfs_pkg::OP_READ: begin
            if (found) begin
              v_re = 1'b1;
              done = 1'b0;
            end else begin
              err_d = sfs_pkg::ERR_NOT_FOUND;
            end
          end
          sfs_pkg::OP_WRITE: begin
            if (found) v_we = out_free;
            else err_d = sfs_pkg::ERR_NOT_FOUND;
          end
          default: begin
            if (found) begin
              m_we    = out_free;
              m_waddr = item_q.var_id[sfs_pkg::MaskAw-1:0];
              m_wdata = m_rdata & ~(MaxFrames'(1) << fidx);
            end else begin
              err_d = sfs_pkg::ERR_NOT_FOUND;
            end
          end
        endcase
      end
      sfs_pkg::ST_RDATA: begin
        done = out_free;
        rd_d = v_rdata;
      end
      sfs_pkg::ST_SWEEP: begin
        // read entry n while writing back entry n-1 with the column cleared
        m_re    = (cnt_q < sfs_pkg::SweepW'(sfs_pkg::IdCount));
        m_raddr = cnt_q[sfs_pkg::MaskAw-1:0];
        m_we    = (cnt_q != '0);
        m_waddr = cnt_m1[sfs_pkg::MaskAw-1:0];
        m_wdata = m_rdata & ~(MaxFrames'(1) << col_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (deq_o) item_q <= q_item_i;
    if (done) begin
      rd_q  <= rd_d;
      pp_q  <= pp_d;
      pa_q  <= pa_d;
      err_q <= err_d;
    end
    if (fc_dec) col_q <= top;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfs_pkg::ST_CLEAR;
      pc_q        <= '0;
      fc_q        <= sfs_pkg::FcW'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < MaxFrames; k++) faddr_q[k] <= (k == 0) ? '1 : '0;
    end else begin
      state_q <= state_d;
      if (pc_inc) pc_q <= pc_q + 1'b1;
      if (pc_dec) pc_q <= pc_m1;
      if (fc_inc) begin
        faddr_q[fc_q[sfs_pkg::FrameW-1:0]] <= item_q.return_address;
        fc_q <= fc_q + 1'b1;
      end
      if (fc_dec) fc_q <= fc_m1;
      if (fc_dec) cnt_q <= '0;
      else if (state_q == sfs_pkg::ST_CLEAR || state_q == sfs_pkg::ST_SWEEP) cnt_q <= cnt_q + 1'b1;
      if (done) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  sfs_ram #(.Width(MaxFrames), .Depth(sfs_pkg::IdCount)) u_mask_ram (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .re_i(m_re), .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  sfs_ram #(.Width(sfs_pkg::ValW), .Depth(sfs_pkg::IdCount * MaxFrames)) u_var_ram (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .re_i(v_re), .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  sfs_ram #(.Width(sfs_pkg::ParamW), .Depth(sfs_pkg::ParamDepth)) u_param_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = rd_q;
  assign popped_param_o   = pp_q;
  assign popped_address_o = pa_q;
  assign error_code_o     = err_q;

  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= sfs_pkg::FcW'(MaxFrames)) else $error("frame count out of range");
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= sfs_pkg::PcW'(sfs_pkg::ParamDepth)) else $error("param count out of range");
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == sfs_pkg::ST_EXEC || state_q == sfs_pkg::ST_RDATA))
    else $error("result outside execute");
  a_deq_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |=> state_q == sfs_pkg::ST_EXEC) else $error("dequeued item not executed");

endmodule

[hdl/scoped_variable_frame_store.sv]
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | action_i var_id_i new_value_i param_value_i
//         |            |             | return_address_i
// out     | out_valid_o| out_stall_i | read_value_o popped_param_o popped_address_o
//         |            |             | error_code_o
// Items pass a 2-entry queue; a found read needs a read-data state after execute.
// Pop frame sweeps the presence mask RAM, one id a cycle, clearing the popped column.
// After reset all 256 mask RAM entries are cleared; items queue meanwhile.
// The back end may take the next item while the last result waits, but not finish it.
module scoped_variable_frame_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        action_i,
  input  logic [sfs_pkg::IdW-1:0]           var_id_i,
  input  logic signed [sfs_pkg::ValW-1:0]   new_value_i,
  input  logic signed [sfs_pkg::ParamW-1:0] param_value_i,
  input  logic signed [sfs_pkg::ValW-1:0]   return_address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sfs_pkg::ValW-1:0]   read_value_o,
  output logic signed [sfs_pkg::ParamW-1:0] popped_param_o,
  output logic signed [sfs_pkg::ValW-1:0]   popped_address_o,
  output logic [2:0]                        error_code_o
);

  logic               q_valid, deq;
  sfs_pkg::sfs_item_t q_item;

  sfs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .var_id_i,
    .new_value_i, .param_value_i, .return_address_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .deq_i(deq)
  );

  sfs_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .deq_o(deq),
    .out_valid_o, .out_stall_i, .read_value_o, .popped_param_o,
    .popped_address_o, .error_code_o
  );

endmodule
